### rtl/mpeg_audio_header_sync_macros.svh
// ----------------------------------------------------------------------------
// mpeg_audio_header_sync_macros
// Assertion macros for the MPEG audio header sync block.
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_HEADER_SYNC_MACROS_SVH
`define MPEG_AUDIO_HEADER_SYNC_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle
`define MAHS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mahs assertion failed");

// condition must hold in the next cycle
`define MAHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mahs assertion failed");

`else

`define MAHS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MAHS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/mahs_pkg.sv
// ----------------------------------------------------------------------------
// mahs_pkg
// Request types and constants for the MPEG audio header sync block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mahs_pkg;

  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_FORGET  = 2'd2;

  localparam logic [7:0] SYNC_BYTE   = 8'hff;
  localparam logic [3:0] SYNC_NIBBLE = 4'hf;
  localparam logic [3:0] BAD_BITRATE = 4'd15;
  localparam logic [1:0] BAD_RATE    = 2'd3;
  localparam logic [1:0] LAYER_III   = 2'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } mahs_in_t;

  typedef struct packed {
    logic        status;
    logic        version_id;
    logic [1:0]  layer_code;
    logic        protection_absent;
    logic [3:0]  bitrate_index;
    logic [1:0]  rate_index;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  emphasis_code;
    logic [3:0]  flag_bits;
    logic [15:0] crc_word;
    logic [31:0] header_offset;
  } mahs_out_t;

endpackage

### rtl/mpeg_audio_header_sync.sv
// ----------------------------------------------------------------------------
// mpeg_audio_header_sync
// Takes one stream byte or restart or forget command per request, hunts for
// the 12-bit MPEG audio sync word, collects the rest of the 4-byte header and
// the optional 2-byte CRC, checks the bitrate and sample rate indexes and the
// fields locked from the first good header, and emits one header request per
// accepted header with its byte offset. Throughput is one byte per cycle: the
// phase update is a few compares on the incoming byte, and a finished header
// lands in an output register backed by one skid entry, so byte_stall only
// rises while both are full. A finished header is registered into hdr_info, or
// into the skid entry while the output register is held by hdr_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mpeg_audio_header_sync_macros.svh"

module mpeg_audio_header_sync (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  mahs_pkg::mahs_in_t byte_req,
  output logic               hdr_valid,
  input  logic               hdr_stall,
  output mahs_pkg::mahs_out_t hdr_info
);

  import mahs_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT_FF,
    PH_HUNT_F0,
    PH_HDR_B2,
    PH_HDR_B3,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] header_bits, header_bits_next;
  logic [15:0] crc_hold, crc_hold_next;
  logic        lock_valid, lock_valid_next;
  logic [8:0]  locked_fields, locked_fields_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] sync_offset, sync_offset_next;

  logic        skid_valid;
  mahs_out_t   skid_info;

  logic        in_fire;
  logic        out_fire;
  logic        gen;
  logic [23:0] hdr_cur;
  logic [15:0] crc_cur;
  logic [8:0]  key_cur;
  mahs_out_t   res;

  assign byte_stall = skid_valid;
  assign in_fire    = byte_valid && !skid_valid;
  assign out_fire   = hdr_valid && !hdr_stall;

  assign hdr_cur = (phase == PH_HDR_B3) ? {header_bits[23:8], byte_req.data_byte}
                                        : header_bits;
  assign crc_cur = (phase == PH_CRC_LO) ? {crc_hold[15:8], byte_req.data_byte}
                                        : 16'd0;
  assign key_cur = {hdr_cur[19], hdr_cur[18:17], hdr_cur[16], hdr_cur[11:10],
                    hdr_cur[7:6], hdr_cur[2]};

  always_comb begin
    res.status            = (hdr_cur[18:17] != LAYER_III);
    res.version_id        = hdr_cur[19];
    res.layer_code        = hdr_cur[18:17];
    res.protection_absent = hdr_cur[16];
    res.bitrate_index     = hdr_cur[15:12];
    res.rate_index        = hdr_cur[11:10];
    res.channel_mode      = hdr_cur[7:6];
    res.mode_extension    = hdr_cur[5:4];
    res.emphasis_code     = hdr_cur[1:0];
    res.flag_bits         = {hdr_cur[9], hdr_cur[8], hdr_cur[3], hdr_cur[2]};
    res.crc_word          = crc_cur;
    res.header_offset     = sync_offset;
  end

  always_comb begin
    phase_next         = phase;
    header_bits_next   = header_bits;
    crc_hold_next      = crc_hold;
    lock_valid_next    = lock_valid;
    locked_fields_next = locked_fields;
    byte_position_next = byte_position;
    sync_offset_next   = sync_offset;
    gen                = 1'b0;
    if (byte_req.action != ACT_DATA) begin
      phase_next         = PH_HUNT_FF;
      header_bits_next   = 24'd0;
      crc_hold_next      = 16'd0;
      byte_position_next = 32'd0;
      if (byte_req.action[1]) begin
        lock_valid_next    = 1'b0;
        locked_fields_next = 9'd0;
      end
    end else begin
      byte_position_next = byte_position + 32'd1;
      case (phase)
        PH_HUNT_FF: begin
          if (byte_req.data_byte == SYNC_BYTE) begin
            sync_offset_next = byte_position;
            phase_next       = PH_HUNT_F0;
          end
        end
        PH_HUNT_F0: begin
          if (byte_req.data_byte[7:4] == SYNC_NIBBLE) begin
            header_bits_next = {byte_req.data_byte, 16'd0};
            phase_next       = PH_HDR_B2;
          end else begin
            phase_next = PH_HUNT_FF;
          end
        end
        PH_HDR_B2: begin
          header_bits_next = {header_bits[23:16], byte_req.data_byte, 8'd0};
          phase_next       = PH_HDR_B3;
        end
        PH_HDR_B3: begin
          header_bits_next = hdr_cur;
          phase_next       = PH_HUNT_FF;
          if (hdr_cur[15:12] != BAD_BITRATE && hdr_cur[11:10] != BAD_RATE) begin
            if (!lock_valid || key_cur == locked_fields) begin
              if (!lock_valid) begin
                lock_valid_next    = 1'b1;
                locked_fields_next = key_cur;
              end
              if (!hdr_cur[16]) begin
                phase_next = PH_CRC_HI;
              end else begin
                gen = 1'b1;
              end
            end
          end
        end
        PH_CRC_HI: begin
          crc_hold_next = {byte_req.data_byte, 8'd0};
          phase_next    = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_hold_next = crc_cur;
          phase_next    = PH_HUNT_FF;
          gen           = 1'b1;
        end
        default: begin
          phase_next = PH_HUNT_FF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT_FF;
      header_bits   <= 24'd0;
      crc_hold      <= 16'd0;
      lock_valid    <= 1'b0;
      locked_fields <= 9'd0;
      byte_position <= 32'd0;
      sync_offset   <= 32'd0;
      hdr_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase         <= phase_next;
        header_bits   <= header_bits_next;
        crc_hold      <= crc_hold_next;
        lock_valid    <= lock_valid_next;
        locked_fields <= locked_fields_next;
        byte_position <= byte_position_next;
        sync_offset   <= sync_offset_next;
      end
      if (!hdr_valid || out_fire) begin
        if (skid_valid) begin
          hdr_info   <= skid_info;
          hdr_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          hdr_info  <= res;
          hdr_valid <= in_fire && gen;
        end
      end else if (in_fire && gen) begin
        skid_info  <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  `MAHS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, hdr_valid)
  `MAHS_ASSERT_NOW(a_status_layer, clk, rst, hdr_valid,
    hdr_info.status == (hdr_info.layer_code != LAYER_III))
  `MAHS_ASSERT_NOW(a_index_ok, clk, rst, hdr_valid,
    hdr_info.bitrate_index != BAD_BITRATE && hdr_info.rate_index != BAD_RATE)
  `MAHS_ASSERT_NOW(a_crc_absent_zero, clk, rst, hdr_valid && hdr_info.protection_absent,
    hdr_info.crc_word == 16'd0)
  `MAHS_ASSERT_NEXT(a_hdr_hold, clk, rst, hdr_valid && hdr_stall,
    hdr_valid && $stable(hdr_info))

endmodule
